// ----- rtl/core/ufs_pkg.sv -----
package ufs_pkg;

    // widths
    localparam int COUNT_W = 16;
    localparam int CAP_W   = 16;
    localparam int LIM_W   = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
    localparam int PORT_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int QCNT_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_CAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_CAP   = 2'd2;

    // capacity reset values
    localparam logic [CAP_W-1:0] SCHEME_CAP_RST = 16'd16;
    localparam logic [CAP_W-1:0] HOST_CAP_RST   = 16'd64;
    localparam logic [CAP_W-1:0] PATH_CAP_RST   = 16'd256;

    // character codes
    localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        PH_SCHEME,
        PH_SEP1,
        PH_SEP2,
        PH_HOST,
        PH_PORT,
        PH_LEAD,
        PH_PATH,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_SCHEME,
        TAG_HOST,
        TAG_PATH
    } t_tag;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TOO_BIG,
        ST_INVALID
    } t_status;

    typedef struct packed {
        t_tag              field_tag;
        logic [CHAR_W-1:0] out_byte;
        logic              done_res;
        t_status           status;
        logic              port_present;
        logic [PORT_W-1:0] port_value;
        logic              last;
    } t_result;

    // up to two result words handed to the output queue in one cycle
    typedef struct packed {
        logic [QCNT_W-1:0] num;
        t_result           r0;
        t_result           r1;
    } t_push;

    typedef struct packed {
        logic [CAP_W-1:0] scheme_cap;
        logic [CAP_W-1:0] host_cap;
        logic [CAP_W-1:0] path_cap;
    } t_cfg;

    function automatic t_result make_res(t_tag tag, logic [CHAR_W-1:0] b, logic done,
                                         t_status st, logic ps, logic [PORT_W-1:0] pv);
        t_result r;
        r.field_tag    = tag;
        r.out_byte     = b;
        r.done_res     = done;
        r.status       = st;
        r.port_present = ps;
        r.port_value   = pv;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/core/ufs_char_if.sv -----
interface ufs_char_if;
    import ufs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// ----- rtl/core/ufs_res_if.sv -----
interface ufs_res_if;
    import ufs_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        field_tag;
    logic [CHAR_W-1:0] out_byte;
    logic              done_res;
    logic [1:0]        status;
    logic              port_present;
    logic [PORT_W-1:0] port_value;
    logic              last;

    modport source (output valid, output field_tag, output out_byte, output done_res,
                    output status, output port_present, output port_value, output last,
                    input ready);
    modport sink   (input valid, input field_tag, input out_byte, input done_res,
                    input status, input port_present, input port_value, input last,
                    output ready);
endinterface

// ----- rtl/core/ufs_parser.sv -----
module ufs_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ufs_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    input  logic [ufs_pkg::CHAR_W-1:0] i_char,
    input  logic [ufs_pkg::QCNT_W-1:0] i_free,
    output logic                      o_commit,
    output ufs_pkg::t_push            o_push
);
    import ufs_pkg::*;

    t_phase            r_phase, n_phase;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic              r_tb, n_tb;
    logic              r_inv, n_inv;
    logic [PORT_W-1:0] r_port, n_port;
    logic              r_seen, n_seen;

    logic [CAP_W-1:0]  slim, hlim, plim;
    logic              do_slash, do_emit, do_done, fits, second_on, inv_done;
    t_tag              emit_tag;
    logic [LIM_W-1:0]  emit_lim;
    logic [COUNT_W-1:0] cnt_base;
    logic [CHAR_W-1:0] digit;
    logic [QCNT_W-1:0] num;
    t_status           st_done;
    t_result           res0, res1, second;

    // field limits, capacity minus terminator (and slash for the path)
    assign slim = (i_cfg.scheme_cap == '0) ? '0 : i_cfg.scheme_cap - 1'b1;
    assign hlim = (i_cfg.host_cap == '0) ? '0 : i_cfg.host_cap - 1'b1;
    assign plim = (i_cfg.path_cap < CAP_W'(2)) ? '0 : i_cfg.path_cap - CAP_W'(2);
    assign digit = i_char - CH_ZERO;

    // phase decode for one byte
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_tb     = r_tb;
        n_inv    = r_inv;
        n_port   = r_port;
        n_seen   = r_seen;
        do_slash = 1'b0;
        do_emit  = 1'b0;
        do_done  = 1'b0;
        emit_tag = TAG_NONE;
        emit_lim = '0;
        inv_done = r_inv;

        if (i_char == CH_END) begin
            do_done = 1'b1;
            case (r_phase)
                PH_SCHEME, PH_SEP1, PH_SEP2: inv_done = 1'b1;
                PH_HOST, PH_PORT, PH_LEAD:   do_slash = 1'b1;
                default: ;
            endcase
        end else begin
            case (r_phase)
                PH_SCHEME: begin
                    if (i_char == CH_COLON) begin
                        n_phase = PH_SEP1;
                        n_cnt   = '0;
                    end else begin
                        do_emit  = 1'b1;
                        emit_tag = TAG_SCHEME;
                        emit_lim = LIM_W'(slim);
                    end
                end
                PH_SEP1, PH_SEP2: begin
                    if (i_char == CH_SLASH) begin
                        n_phase = (r_phase == PH_SEP1) ? PH_SEP2 : PH_HOST;
                    end else begin
                        n_inv   = 1'b1;
                        n_phase = PH_SKIP;
                    end
                end
                PH_HOST: begin
                    if (i_char == CH_SLASH) begin
                        n_phase = PH_LEAD;
                    end else if (i_char == CH_COLON) begin
                        n_seen  = 1'b1;
                        n_phase = PH_PORT;
                    end else if (i_char == CH_SPACE) begin
                        do_slash = 1'b1;
                        do_emit  = 1'b1;
                        emit_tag = TAG_PATH;
                        emit_lim = LIM_W'(plim);
                    end else begin
                        do_emit  = 1'b1;
                        emit_tag = TAG_HOST;
                        emit_lim = LIM_W'(hlim);
                    end
                end
                PH_PORT: begin
                    if (i_char >= CH_ZERO && i_char <= CH_NINE) begin
                        n_port = (r_port << 3) + (r_port << 1) + PORT_W'(digit);
                    end else if (i_char == CH_SLASH) begin
                        n_phase = PH_LEAD;
                    end else begin
                        do_slash = 1'b1;
                        do_emit  = 1'b1;
                        emit_tag = TAG_PATH;
                        emit_lim = LIM_W'(plim);
                    end
                end
                PH_LEAD: begin
                    if (i_char != CH_SLASH) begin
                        do_slash = 1'b1;
                        do_emit  = 1'b1;
                        emit_tag = TAG_PATH;
                        emit_lim = LIM_W'(plim);
                    end
                end
                PH_PATH: begin
                    do_emit  = 1'b1;
                    emit_tag = TAG_PATH;
                    emit_lim = LIM_W'(plim);
                end
                default: ;
            endcase
        end

        // path start resets the count
        cnt_base = do_slash ? '0 : r_cnt;
        fits = (LIM_W'(cnt_base) < emit_lim) && (cnt_base != {COUNT_W{1'b1}});
        if (do_slash) begin
            n_phase = PH_PATH;
            n_cnt   = '0;
        end
        if (do_emit) begin
            if (fits) begin
                n_cnt = cnt_base + 1'b1;
            end else begin
                n_tb = 1'b1;
            end
        end

        // end byte returns the parser to its idle state
        if (do_done) begin
            n_phase = PH_SCHEME;
            n_cnt   = '0;
            n_tb    = 1'b0;
            n_inv   = 1'b0;
            n_port  = '0;
            n_seen  = 1'b0;
        end
    end

    // result words in emission order
    always_comb begin
        st_done = inv_done ? ST_INVALID : (r_tb ? ST_TOO_BIG : ST_OK);
        second  = do_done ? make_res(TAG_NONE, CH_END, 1'b1, st_done, r_seen, r_port)
                          : make_res(emit_tag, i_char, 1'b0, ST_OK, r_seen, r_port);
        second_on = do_done || (do_emit && fits);
        res0 = '0;
        res1 = '0;
        num  = '0;
        if (do_slash) begin
            res0 = make_res(TAG_PATH, CH_SLASH, 1'b0, ST_OK, r_seen, r_port);
            if (second_on) begin
                res1 = second;
                num  = QCNT_W'(2);
            end else begin
                num  = QCNT_W'(1);
            end
        end else if (second_on) begin
            res0 = second;
            num  = QCNT_W'(1);
        end
        if (num == QCNT_W'(2)) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    assign o_commit   = i_valid && (num <= i_free);
    assign o_push.num = o_commit ? num : '0;
    assign o_push.r0  = res0;
    assign o_push.r1  = res1;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCHEME;
            r_cnt   <= '0;
            r_tb    <= 1'b0;
            r_inv   <= 1'b0;
            r_port  <= '0;
            r_seen  <= 1'b0;
        end else if (o_commit) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_tb    <= n_tb;
            r_inv   <= n_inv;
            r_port  <= n_port;
            r_seen  <= n_seen;
        end
    end

endmodule

// ----- rtl/core/ufs_outq.sv -----
module ufs_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ufs_pkg::t_push             i_push,
    input  logic                       i_pop,
    output logic                       o_valid,
    output ufs_pkg::t_result           o_head,
    output logic [ufs_pkg::QCNT_W-1:0] o_free
);
    import ufs_pkg::*;

    t_result           r_s0, r_s1, n_s0, n_s1;
    logic [QCNT_W-1:0] r_cnt, n_cnt, rem;
    logic              pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_s0;
    assign o_free  = QCNT_W'(2) - r_cnt;
    assign rem     = r_cnt - QCNT_W'(pop);

    // shift out the head, then append new words behind what remains
    always_comb begin
        n_s0 = pop ? r_s1 : r_s0;
        n_s1 = r_s1;
        if (i_push.num != '0) begin
            if (rem == '0) begin
                n_s0 = i_push.r0;
            end else begin
                n_s1 = i_push.r0;
            end
        end
        if (i_push.num == QCNT_W'(2)) begin
            n_s1 = i_push.r1;
        end
        n_cnt = rem + i_push.num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        r_s1 <= n_s1;
    end

endmodule

// ----- rtl/core/url_field_splitter.sv -----
// url_field_splitter: splits a URL of the form SCHEME://HOST[:PORT]/PATH.
// i_in carries one URL byte per word (char_in); byte 0 ends the URL and the
// parser returns to its start state afterwards, keeping the capacities.
// o_out carries result words: a field tag with its byte, and on the end byte
// a done word with status and the parsed port. last marks the final word
// caused by one input byte; a byte may cause zero, one or two words.
// The capacity registers are written over i_cfg_we / i_cfg_index /
// i_cfg_data; index 0 scheme, 1 host, 2 path. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A byte is registered on acceptance and its words in the output queue.
// Throughput: one byte per cycle while each byte yields at most one word
// and the receiver takes every word. A byte yielding two words is taken
// only into an empty output queue, so after a word-producing byte it waits
// for the queue to drain, and the next byte waits while the second word
// goes out. When the receiver stalls, the output queue holds up to two
// words, the input register one byte; i_in.ready drops once these are full.
// Synchronous active-low reset clears the parser, the queue and the input
// register, and restores the capacities to 16, 64 and 256.
module url_field_splitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ufs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ufs_pkg::CAP_W-1:0]     i_cfg_data,
    ufs_char_if.sink                      i_in,
    ufs_res_if.source                     o_out
);
    import ufs_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              commit;
    logic [QCNT_W-1:0] free;
    t_push             push;
    t_result           head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scheme_cap <= SCHEME_CAP_RST;
            r_cfg.host_cap   <= HOST_CAP_RST;
            r_cfg.path_cap   <= PATH_CAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCHEME_CAP: r_cfg.scheme_cap <= i_cfg_data;
                CFG_HOST_CAP:   r_cfg.host_cap   <= i_cfg_data;
                CFG_PATH_CAP:   r_cfg.path_cap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register, refilled as the parser consumes it
    assign i_in.ready = !r_in_valid || commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.char_in;
        end
    end

    ufs_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (r_in_valid),
        .i_char   (r_in_char),
        .i_free   (free),
        .o_commit (commit),
        .o_push   (push)
    );

    ufs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_head  (head),
        .o_free  (free)
    );

    // output word fields
    assign o_out.field_tag    = head.field_tag;
    assign o_out.out_byte     = head.out_byte;
    assign o_out.done_res     = head.done_res;
    assign o_out.status       = head.status;
    assign o_out.port_present = head.port_present;
    assign o_out.port_value   = head.port_value;
    assign o_out.last         = head.last;

endmodule

// ----- rtl/core/ufs_checker.sv -----
module ufs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_field_tag,
    input logic [7:0] i_out_byte,
    input logic       i_done_res,
    input logic [1:0] i_status,
    input logic       i_last
);
    import ufs_pkg::*;

    // a stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // the done word always closes its byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> i_last)
        else $error("done word without last");

    // status only on done words
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_done_res |-> i_status == ST_OK)
        else $error("status on a field word");

    // an untagged word is only the done word, with a zero byte
    a_untagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_field_tag == TAG_NONE |-> i_done_res && i_out_byte == CH_END)
        else $error("untagged word that is not done");

endmodule

bind url_field_splitter ufs_checker u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_field_tag (o_out.field_tag),
    .i_out_byte  (o_out.out_byte),
    .i_done_res  (o_out.done_res),
    .i_status    (o_out.status),
    .i_last      (o_out.last)
);
